### rtl/core/lfps_pkg.sv
// lfps_pkg: types, constants and table functions for the PID line follower core.
// No dependencies; imported by line_follower_pid_steering and tb.
package lfps_pkg;

	localparam int IDX_W   = 3;
	localparam int ERR_W   = 11;
	localparam int DE_W    = 12;
	localparam int MUL_A_W = 33;
	localparam int MUL_B_W = 23;
	localparam int PROD_W  = MUL_A_W + MUL_B_W;
	localparam int PWM_W   = 10;
	localparam int SPD_W   = 10;
	localparam int STEER_W = 11;
	localparam int PV_W    = 21;
	localparam int Q_W     = 11;

	localparam logic [IDX_W-1:0] IDX_CENTER = 3'd3;

	localparam logic [16:0] DECAY_MUL  = 17'd65405;
	localparam logic [21:0] RECIP_1000 = 22'd2147484;
	localparam int          RECIP_SH   = 31;
	localparam logic [SPD_W-1:0] SPEED_FULL = 10'd1000;
	localparam logic [PWM_W-1:0] PWM_MAX    = 10'd1023;

	localparam int PADDR_W = 5;

	typedef enum logic [2:0] {
		REG_INVERT = 3'd0,
		REG_PGAIN  = 3'd1,
		REG_DGAIN  = 3'd2,
		REG_IGDT   = 3'd3,
		REG_LTOP   = 3'd4,
		REG_RTOP   = 3'd5,
		REG_BRAKE  = 3'd6
	} reg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MP,
		ST_MI,
		ST_MD,
		ST_MG,
		ST_SUM,
		ST_STEER,
		ST_ML,
		ST_MR,
		ST_QL,
		ST_QR,
		ST_DONE,
		ST_OUT
	} state_t;

	function automatic logic signed [ERR_W-1:0] err_of(input logic [IDX_W-1:0] idx);
		logic signed [ERR_W-1:0] r;
		case (idx)
			3'd0:    r = 11'sd1000;
			3'd1:    r = 11'sd400;
			3'd2:    r = 11'sd200;
			3'd4:    r = -11'sd200;
			3'd5:    r = -11'sd400;
			3'd6:    r = -11'sd1000;
			default: r = '0;
		endcase
		return r;
	endfunction

	// bound in Q11.20
	function automatic logic signed [31:0] bound_of(input logic [IDX_W-1:0] idx);
		logic signed [31:0] r;
		case (idx)
			3'd0:    r = 32'sd450 <<< 20;
			3'd1:    r = 32'sd350 <<< 20;
			3'd2:    r = 32'sd250 <<< 20;
			3'd4:    r = -(32'sd250 <<< 20);
			3'd5:    r = -(32'sd350 <<< 20);
			3'd6:    r = -(32'sd450 <<< 20);
			default: r = '0;
		endcase
		return r;
	endfunction

	// arithmetic right shift rounding toward zero
	function automatic logic signed [63:0] trunc_shr(input logic signed [63:0] a,
			input int unsigned sh);
		logic signed [63:0] m;
		m = -a;
		return a[63] ? -(m >>> sh) : (a >>> sh);
	endfunction

endpackage

### rtl/core/line_follower_pid_steering.sv
// line_follower_pid_steering: PID steering core for a seven-sensor line follower.
// Uses lfps_pkg; one shared signed multiplier runs under a small sequencer.
//
//  channel  | signals                          | carries
//  ---------+----------------------------------+------------------------------------
//  s_       | s_tvalid s_tready s_tdata[7:0]   | one sensor sample request
//  m_       | m_tvalid m_tready m_tdata[39:0]  | pwm compares, directions, steering
//  apb      | psel penable pwrite paddr pwdata | seven control registers, readable
//
// Each sample makes eight passes through the 33x23 multiplier plus accumulate, steer
// and load steps; a new sample is accepted only once the sequencer is back in idle.
// s_tready is high only while the sequencer is idle; a loaded result waits in the
// output register and the next sample may be accepted meanwhile.
// A stalled result holds the sequencer in its final step until taken.
// Reset restores register defaults, centered indexes, zero PID terms, forward drive.
module line_follower_pid_steering (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [7:0]                       s_tdata,   // [6:0] sensor_bits
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// [9:0] left_pwm, [19:10] right_pwm, [20] left_forward, [21] right_forward,
	// [32:22] steering, [33] line_lost
	output logic [39:0]                      m_tdata,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [lfps_pkg::PADDR_W-1:0]     paddr,
	input  logic [31:0]                      pwdata,
	output logic [31:0]                      prdata,
	output logic                             pready
);
	import lfps_pkg::*;

	// control registers
	logic        invert_q;
	logic [11:0] prop_gain_q;
	logic [11:0] deriv_gain_q;
	logic [15:0] igdt_q;
	logic [9:0]  ltop_q;
	logic [9:0]  rtop_q;
	logic [9:0]  brake_q;

	// loop state
	logic [IDX_W-1:0]  active_q;
	logic [IDX_W-1:0]  loc_q;
	logic [IDX_W-1:0]  prev_q;
	logic signed [31:0] integ_q;
	logic signed [31:0] deriv_q;
	logic              ldir_q;
	logic              rdir_q;

	// per-sample working registers
	state_t                     state_q, state_d;
	logic signed [ERR_W-1:0]    e_q;
	logic signed [DE_W-1:0]     de_q;
	logic                       seen_q;
	logic signed [15:0]         prop_q;
	logic signed [32:0]         dec_q;
	logic signed [STEER_W-1:0]  steer_q;
	logic [SPD_W-1:0]           lspd_q;
	logic [SPD_W-1:0]           rspd_q;
	logic [PV_W-1:0]            vl_q;
	logic [PV_W-1:0]            vr_q;
	logic [PWM_W-1:0]           lpwm_q;
	logic [PWM_W-1:0]           rpwm_q;
	logic signed [PROD_W-1:0]   prod_q;
	logic                       m_valid_q;
	logic [39:0]                m_data_q;

	// shared multiplier operands
	logic signed [MUL_A_W-1:0] mul_a;
	logic signed [MUL_B_W-1:0] mul_b;

	// scan
	logic [6:0]       sbits;
	logic             scan_seen;
	logic [IDX_W-1:0] scan_act;
	logic [IDX_W-1:0] scan_loc;

	// arithmetic
	logic signed [63:0]         t_prop;
	logic signed [63:0]         t_dec;
	logic signed [63:0]         t_iwhole;
	logic signed [63:0]         t_steer;
	logic signed [33:0]         i_sum;
	logic signed [33:0]         i_bound;
	logic signed [31:0]         i_new;
	logic signed [33:0]         d_sum;
	logic signed [31:0]         d_new;
	logic signed [16:0]         pi_sum;
	logic signed [33:0]         total;
	logic signed [25:0]         steer_full;
	logic signed [STEER_W-1:0]  steer_c;
	logic [Q_W-1:0]             quot;
	logic [PWM_W-1:0]           pwm_sat;
	logic                       cfg_wr;
	logic                       in_acc;
	logic                       out_free;
	logic                       out_load;

	assign pready   = 1'b1;
	assign cfg_wr   = psel && penable && pwrite && pready;
	assign s_tready = (state_q == ST_IDLE);
	assign in_acc   = s_tvalid && s_tready;
	assign out_free = !m_valid_q || m_tready;
	assign out_load = (state_q == ST_OUT) && out_free;
	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			invert_q     <= 1'b0;
			prop_gain_q  <= 12'd512;
			deriv_gain_q <= 12'd256;
			igdt_q       <= 16'd1258;
			ltop_q       <= 10'd400;
			rtop_q       <= 10'd380;
			brake_q      <= 10'd600;
		end else if (cfg_wr) begin
			case (reg_idx_t'(paddr[4:2]))
				REG_INVERT: invert_q     <= pwdata[0];
				REG_PGAIN:  prop_gain_q  <= pwdata[11:0];
				REG_DGAIN:  deriv_gain_q <= pwdata[11:0];
				REG_IGDT:   igdt_q       <= pwdata[15:0];
				REG_LTOP:   ltop_q       <= pwdata[9:0];
				REG_RTOP:   rtop_q       <= pwdata[9:0];
				REG_BRAKE:  brake_q      <= pwdata[9:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx_t'(paddr[4:2]))
			REG_INVERT: prdata = {31'd0, invert_q};
			REG_PGAIN:  prdata = {20'd0, prop_gain_q};
			REG_DGAIN:  prdata = {20'd0, deriv_gain_q};
			REG_IGDT:   prdata = {16'd0, igdt_q};
			REG_LTOP:   prdata = {22'd0, ltop_q};
			REG_RTOP:   prdata = {22'd0, rtop_q};
			REG_BRAKE:  prdata = {22'd0, brake_q};
			default:    prdata = '0;
		endcase
	end

	// priority scan from the outer pair inwards
	always_comb begin
		sbits     = invert_q ? ~s_tdata[6:0] : s_tdata[6:0];
		scan_seen = 1'b0;
		scan_act  = active_q;
		scan_loc  = loc_q;
		for (int i = 0; i < 3; i++) begin
			if (!scan_seen) begin
				if (sbits[i] && sbits[6-i]) begin
					scan_act  = IDX_CENTER;
					scan_seen = 1'b1;
				end else if (sbits[i]) begin
					scan_act  = IDX_W'(i);
					scan_loc  = IDX_W'(i);
					scan_seen = 1'b1;
				end else if (sbits[6-i]) begin
					scan_act  = IDX_W'(6 - i);
					scan_loc  = IDX_W'(6 - i);
					scan_seen = 1'b1;
				end
			end
		end
		if (!scan_seen && sbits[3]) begin
			scan_act  = IDX_CENTER;
			scan_seen = 1'b1;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		mul_a   = '0;
		mul_b   = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc) state_d = ST_MP;
			end
			ST_MP: begin
				mul_a   = MUL_A_W'(e_q);
				mul_b   = $signed(MUL_B_W'(prop_gain_q));
				state_d = ST_MI;
			end
			ST_MI: begin
				mul_a   = MUL_A_W'(e_q);
				mul_b   = $signed(MUL_B_W'(igdt_q));
				state_d = ST_MD;
			end
			ST_MD: begin
				mul_a   = MUL_A_W'(deriv_q);
				mul_b   = $signed(MUL_B_W'(DECAY_MUL));
				state_d = ST_MG;
			end
			ST_MG: begin
				mul_a   = MUL_A_W'(de_q);
				mul_b   = $signed(MUL_B_W'(deriv_gain_q));
				state_d = ST_SUM;
			end
			ST_SUM:   state_d = ST_STEER;
			ST_STEER: state_d = ST_ML;
			ST_ML: begin
				mul_a   = $signed(MUL_A_W'(lspd_q));
				mul_b   = $signed(MUL_B_W'(ltop_q));
				state_d = ST_MR;
			end
			ST_MR: begin
				mul_a   = $signed(MUL_A_W'(rspd_q));
				mul_b   = $signed(MUL_B_W'(rtop_q));
				state_d = ST_QL;
			end
			ST_QL: begin
				mul_a   = $signed(MUL_A_W'(vl_q));
				mul_b   = $signed(MUL_B_W'(RECIP_1000));
				state_d = ST_QR;
			end
			ST_QR: begin
				mul_a   = $signed(MUL_A_W'(vr_q));
				mul_b   = $signed(MUL_B_W'(RECIP_1000));
				state_d = ST_DONE;
			end
			ST_DONE: state_d = ST_OUT;
			ST_OUT: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// datapath arithmetic
	always_comb begin
		t_prop   = trunc_shr(64'(prod_q), 8);
		t_dec    = trunc_shr(64'(prod_q), 16);

		i_sum    = 34'(integ_q) + $signed(prod_q[33:0]);
		i_bound  = 34'(bound_of(active_q));
		if (i_sum < 0 && i_sum < i_bound) begin
			i_new = i_bound[31:0];
		end else if (i_sum > i_bound) begin
			i_new = i_bound[31:0];
		end else begin
			i_new = i_sum[31:0];
		end

		d_sum = 34'(dec_q) + $signed(prod_q[33:0]);
		if (d_sum[33:31] != 3'b000 && d_sum[33:31] != 3'b111) begin
			d_new = d_sum[33] ? 32'sh8000_0000 : 32'sh7fff_ffff;
		end else begin
			d_new = d_sum[31:0];
		end

		t_iwhole   = trunc_shr(64'(integ_q), 20);
		pi_sum     = 17'(t_iwhole) + 17'(prop_q);
		total      = 34'(deriv_q) + (34'(pi_sum) <<< 8);
		t_steer    = trunc_shr(64'(total), 8);
		steer_full = t_steer[25:0];
		if (steer_full > 26'sd1000) begin
			steer_c = 11'sd1000;
		end else if (steer_full < -26'sd1000) begin
			steer_c = -11'sd1000;
		end else begin
			steer_c = steer_full[STEER_W-1:0];
		end

		quot = prod_q[RECIP_SH+Q_W-1:RECIP_SH];
		pwm_sat = (quot > Q_W'(PWM_MAX)) ? PWM_MAX : quot[PWM_W-1:0];
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					e_q    <= err_of(scan_act);
					de_q   <= DE_W'(err_of(scan_act)) - DE_W'(err_of(prev_q));
					seen_q <= scan_seen;
				end
			end
			ST_MI:   prop_q <= t_prop[15:0];
			ST_MG:   dec_q  <= t_dec[32:0];
			ST_STEER: begin
				steer_q <= steer_c;
				if (!seen_q && loc_q > IDX_CENTER) begin
					rspd_q <= SPEED_FULL;
					lspd_q <= brake_q;
				end else if (!seen_q && loc_q < IDX_CENTER) begin
					rspd_q <= brake_q;
					lspd_q <= SPEED_FULL;
				end else if (steer_c > 0) begin
					rspd_q <= SPD_W'(11'sd1000 - steer_c);
					lspd_q <= SPEED_FULL;
				end else begin
					rspd_q <= SPEED_FULL;
					lspd_q <= SPD_W'(11'sd1000 + steer_c);
				end
			end
			ST_MR:   vl_q   <= prod_q[PV_W-1:0];
			ST_QL:   vr_q   <= prod_q[PV_W-1:0];
			ST_QR:   lpwm_q <= pwm_sat;
			ST_DONE: rpwm_q <= pwm_sat;
			default: ;
		endcase
	end

	// loop state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q  <= IDX_CENTER;
			loc_q     <= IDX_CENTER;
			prev_q    <= IDX_CENTER;
			integ_q   <= '0;
			deriv_q   <= '0;
			ldir_q    <= 1'b1;
			rdir_q    <= 1'b1;
			m_valid_q <= 1'b0;
			m_data_q  <= '0;
		end else begin
			if (out_load) m_valid_q <= 1'b1;
			else if (m_tready) m_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						active_q <= scan_act;
						loc_q    <= scan_loc;
						prev_q   <= scan_act;
					end
				end
				ST_MD:  integ_q <= i_new;
				ST_SUM: deriv_q <= d_new;
				ST_STEER: begin
					if (!seen_q && loc_q > IDX_CENTER) begin
						integ_q <= '0;
						deriv_q <= '0;
						ldir_q  <= 1'b0;
					end else if (!seen_q && loc_q < IDX_CENTER) begin
						integ_q <= '0;
						deriv_q <= '0;
						rdir_q  <= 1'b0;
					end else begin
						ldir_q <= 1'b1;
						rdir_q <= 1'b1;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						m_data_q  <= {6'd0, !seen_q, steer_q, rdir_q, ldir_q, rpwm_q, lpwm_q};
					end
				end
				default: ;
			endcase
		end
	end

endmodule

### sim/tb.sv
// tb: self-checking bench for line_follower_pid_steering over stream and APB ports.
// Predicts each steering result from the sensor samples it accepts; depends on lfps_pkg.
`timescale 1ns / 100ps

module tb;
	import lfps_pkg::*;

	localparam int   WATCHDOG_LIMIT = 4000;
	localparam int   PHASES         = 8;
	localparam int   RANDOM_ITEMS   = 215;
	localparam longint DECAY_Q16    = 65405;

	typedef struct packed {
		logic [9:0]  left_pwm;
		logic [9:0]  right_pwm;
		logic        left_fwd;
		logic        right_fwd;
		logic [10:0] steer;
		logic        lost;
	} drive_t;

	function automatic longint line_error(logic [2:0] idx);
		case (idx)
			3'd0:    return 1000;
			3'd1:    return 400;
			3'd2:    return 200;
			3'd4:    return -200;
			3'd5:    return -400;
			3'd6:    return -1000;
			default: return 0;
		endcase
	endfunction

	function automatic longint integ_bound(logic [2:0] idx);
		case (idx)
			3'd0:    return 450;
			3'd1:    return 350;
			3'd2:    return 250;
			3'd4:    return -250;
			3'd5:    return -350;
			3'd6:    return -450;
			default: return 0;
		endcase
	endfunction

	function automatic longint div_pow2(longint a, int unsigned sh);
		if (a >= 0)
			return a >>> sh;
		return -((-a) >>> sh);
	endfunction

	function automatic longint clip32(longint a);
		if (a > 64'sd2147483647)
			return 64'sd2147483647;
		if (a < -64'sd2147483648)
			return -64'sd2147483648;
		return a;
	endfunction

	function automatic logic [9:0] pwm_compare(longint speed, longint top);
		longint v;
		v = (speed * top) / 1000;
		return (v > 1023) ? 10'd1023 : v[9:0];
	endfunction

	class steer_scoreboard;
		bit         invert;
		longint     p_gain, d_gain, i_gain, l_top, r_top, brake;
		logic [2:0] cur_idx, off_center_idx, last_idx;
		int         integ_acc, deriv_acc;
		bit         l_fwd, r_fwd;
		drive_t     pending_drives[$];
		int         faults;

		function new();
			invert = 0; p_gain = 512; d_gain = 256; i_gain = 1258;
			l_top = 400; r_top = 380; brake = 600;
			cur_idx = 3; off_center_idx = 3; last_idx = 3;
			integ_acc = 0; deriv_acc = 0;
			l_fwd = 1; r_fwd = 1;
			faults = 0;
		endfunction

		function void set_reg(logic [2:0] idx, logic [31:0] v);
			case (reg_idx_t'(idx))
				REG_INVERT: invert = v[0];
				REG_PGAIN:  p_gain = longint'(v[11:0]);
				REG_DGAIN:  d_gain = longint'(v[11:0]);
				REG_IGDT:   i_gain = longint'(v[15:0]);
				REG_LTOP:   l_top  = longint'(v[9:0]);
				REG_RTOP:   r_top  = longint'(v[9:0]);
				REG_BRAKE:  brake  = longint'(v[9:0]);
				default:    ;
			endcase
		endfunction

		function void note_sample(logic [6:0] raw);
			logic [6:0] s;
			bit         seen;
			int         k;
			longint     e, de, prop, integ, bnd, deriv, total, steer, ls, rs;
			drive_t     d;
			s = invert ? ~raw : raw;
			seen = 0;
			for (k = 0; k < 3 && !seen; k++) begin
				if (s[k] && s[6-k]) begin
					cur_idx = 3; seen = 1;
				end else if (s[k]) begin
					cur_idx = 3'(k); off_center_idx = 3'(k); seen = 1;
				end else if (s[6-k]) begin
					cur_idx = 3'(6 - k); off_center_idx = 3'(6 - k); seen = 1;
				end
			end
			if (!seen && s[3]) begin
				cur_idx = 3; seen = 1;
			end
			e = line_error(cur_idx);
			de = e - line_error(last_idx);
			prop = div_pow2(e * p_gain, 8);
			integ = longint'(integ_acc) + e * i_gain;
			bnd = integ_bound(cur_idx) * 1048576;
			// clamp as the DUT does, a negative sum below any bound snaps to it
			if (integ < 0 && integ < bnd)
				integ = bnd;
			else if (integ > bnd)
				integ = bnd;
			integ_acc = int'(clip32(integ));
			deriv = div_pow2(longint'(deriv_acc) * DECAY_Q16, 16) + de * d_gain;
			deriv_acc = int'(clip32(deriv));
			total = longint'(deriv_acc) + (div_pow2(longint'(integ_acc), 20) + prop) * 256;
			steer = div_pow2(total, 8);
			if (steer > 1000)
				steer = 1000;
			else if (steer < -1000)
				steer = -1000;
			if (!seen && off_center_idx > 3) begin
				integ_acc = 0; deriv_acc = 0;
				rs = 1000; ls = brake; l_fwd = 0;
			end else if (!seen && off_center_idx < 3) begin
				integ_acc = 0; deriv_acc = 0;
				ls = 1000; rs = brake; r_fwd = 0;
			end else begin
				l_fwd = 1; r_fwd = 1;
				if (steer > 0) begin
					rs = 1000 - steer; ls = 1000;
				end else begin
					rs = 1000; ls = 1000 + steer;
				end
			end
			last_idx = cur_idx;
			d.left_pwm  = pwm_compare(ls, l_top);
			d.right_pwm = pwm_compare(rs, r_top);
			d.left_fwd  = l_fwd;
			d.right_fwd = r_fwd;
			d.steer     = steer[10:0];
			d.lost      = !seen;
			pending_drives.push_back(d);
		endfunction

		function void check_drive(logic [39:0] t);
			drive_t exp_d, got;
			got.left_pwm  = t[9:0];
			got.right_pwm = t[19:10];
			got.left_fwd  = t[20];
			got.right_fwd = t[21];
			got.steer     = t[32:22];
			got.lost      = t[33];
			if (pending_drives.size() == 0) begin
				faults++;
				if (faults <= 10)
					$display("%0t: unexpected drive result %h", $time, t);
				return;
			end
			exp_d = pending_drives.pop_front();
			if (got != exp_d) begin
				faults++;
				if (faults <= 10)
					$display({"%0t: drive mismatch exp l=%0d r=%0d lf=%0b rf=%0b st=%0d ",
						"lost=%0b got l=%0d r=%0d lf=%0b rf=%0b st=%0d lost=%0b"}, $time,
						exp_d.left_pwm, exp_d.right_pwm, exp_d.left_fwd, exp_d.right_fwd,
						$signed(exp_d.steer), exp_d.lost, got.left_pwm, got.right_pwm,
						got.left_fwd, got.right_fwd, $signed(got.steer), got.lost);
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;    // [6:0] sensor_bits
	logic        m_tvalid;
	logic        m_tready;
	// [9:0] left_pwm, [19:10] right_pwm, [20] left_forward, [21] right_forward,
	// [32:22] steering, [33] line_lost
	logic [39:0] m_tdata;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	steer_scoreboard sb;
	bit          no_idle;
	bit          invert_now;
	int          line_pos;
	int          idle_cycles;

	line_follower_pid_steering u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	initial begin
		sb = new();
		arst_n = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				sb.note_sample(s_tdata[6:0]);
			if (m_tvalid && m_tready)
				sb.check_drive(m_tdata);
			if (psel && penable && pwrite && pready)
				sb.set_reg(paddr[4:2], pwdata);
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("line_follower_pid_steering regression: fail");
			$finish;
		end
	end

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic logic [6:0] line_pattern();
		int         r;
		logic [6:0] pat;
		r = $urandom_range(0, 99);
		if (r < 55) begin
			line_pos = line_pos + $urandom_range(0, 2) - 1;
			if (line_pos < 0)
				line_pos = 0;
			if (line_pos > 6)
				line_pos = 6;
			pat = 7'd1 << line_pos;
			if ($urandom_range(0, 1) && line_pos < 6)
				pat = pat | (pat << 1);
		end else if (r < 75) begin
			pat = '0;
		end else begin
			return 7'($urandom_range(0, 127));
		end
		return invert_now ? ~pat : pat;
	endfunction

	task automatic send_sample(logic [6:0] bits);
		int g;
		s_tvalid <= 1'b1;
		s_tdata  <= {1'b0, bits};
		do @(posedge clk); while (!s_tready);
		g = no_idle ? 0 : gap_len();
		if (g > 0) begin
			s_tvalid <= 1'b0;
			repeat (g) @(posedge clk);
		end
	endtask

	// hold off until every pending result is out and the sequencer is back to idle
	task automatic settle();
		if (s_tvalid)
			s_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.pending_drives.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic apb_write(reg_idx_t idx, logic [31:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic program_regs(bit inv, int pg, int dg, int ig, int lt, int rt, int br);
		apb_write(REG_INVERT, inv);
		apb_write(REG_PGAIN, pg);
		apb_write(REG_DGAIN, dg);
		apb_write(REG_IGDT, ig);
		apb_write(REG_LTOP, lt);
		apb_write(REG_RTOP, rt);
		apb_write(REG_BRAKE, br);
		invert_now = inv;
	endtask

	initial begin
		m_tready <= 1'b0;
		wait (arst_n);
		forever begin
			m_tready <= 1'b1;
			if (no_idle) begin
				@(posedge clk);
			end else begin
				int on, g;
				on = $urandom_range(1, 8);
				repeat (on) @(posedge clk);
				g = gap_len();
				if (g > 0) begin
					m_tready <= 1'b0;
					repeat (g) @(posedge clk);
				end
			end
		end
	end

	initial begin
		logic [6:0] opening[$];
		int         p, k;
		s_tvalid    <= 1'b0;
		s_tdata     <= '0;
		psel        <= 1'b0;
		penable     <= 1'b0;
		pwrite      <= 1'b0;
		paddr       <= '0;
		pwdata      <= '0;
		idle_cycles = 0;
		no_idle     = 0;
		invert_now  = 0;
		line_pos    = 3;
		// lost while centered, outer pair, left off-center then lost, right then lost,
		// each single sensor, inner pairs, repeated hits to drive the integral into its bound
		opening = '{7'h00, 7'h7F, 7'h01, 7'h00, 7'h00, 7'h08, 7'h40, 7'h00, 7'h00,
			7'h02, 7'h20, 7'h04, 7'h10, 7'h03, 7'h60, 7'h41, 7'h22, 7'h14, 7'h1C,
			7'h01, 7'h01, 7'h01, 7'h40, 7'h40, 7'h00};
		wait (arst_n);
		@(posedge clk);
		foreach (opening[k])
			send_sample(opening[k]);
		settle();
		for (k = 0; k < RANDOM_ITEMS - 30; k++)
			send_sample(line_pattern());
		for (p = 1; p < PHASES; p++) begin
			settle();
			case (p)
				1: program_regs(1, 4095, 4095, 65535, 1023, 1023, 1023);
				2: program_regs(0, 0, 0, 0, 0, 0, 0);
				3: program_regs(1, 512, 256, 1258, 1000, 1000, 1000);
				default: program_regs($urandom_range(0, 1), $urandom_range(0, 4095),
					$urandom_range(0, 4095), $urandom_range(0, 65535),
					$urandom_range(0, 1023), $urandom_range(0, 1023),
					$urandom_range(0, 1023));
			endcase
			no_idle = (p == 2 || p == 5);
			for (k = 0; k < RANDOM_ITEMS; k++)
				send_sample(line_pattern());
		end
		no_idle = 0;
		settle();
		if (sb.faults == 0 && sb.pending_drives.size() == 0)
			$display("line_follower_pid_steering regression: pass");
		else
			$display("line_follower_pid_steering regression: fail");
		$finish;
	end

endmodule

### sim.f
rtl/core/lfps_pkg.sv
rtl/core/line_follower_pid_steering.sv
sim/tb.sv
